/* hw/rtl/cbss_pkg.sv */
package cbss_pkg;

  localparam int COORD_WIDTH_DEF = 12;
  localparam int MAX_SMOOTH_DEF  = 63;
  localparam int MIN_SMOOTH      = 3;
  localparam int SMOOTH_W        = 6;
  localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = 6'd10;

  // Main sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  // Steps of the shared multiplier. The order matters: each step may only use
  // a result that was committed before it issues; OP_S3 takes the product directly.
  typedef enum logic [4:0] {
    OP_SS  = 5'd0,   // s * s
    OP_S3  = 5'd1,   // (s * s) * s, first operand forwarded from the product
    OP_RR  = 5'd2,   // r * r
    OP_II  = 5'd3,   // i * i
    OP_W0  = 5'd4,   // r^2 * r
    OP_T1  = 5'd5,   // r^2 * i, committed times three
    OP_T2  = 5'd6,   // i^2 * r, committed times three
    OP_W3  = 5'd7,   // i^2 * i
    OP_X0  = 5'd8,
    OP_X1  = 5'd9,
    OP_X2  = 5'd10,
    OP_X3  = 5'd11,
    OP_Y0  = 5'd12,
    OP_Y1  = 5'd13,
    OP_Y2  = 5'd14,
    OP_Y3  = 5'd15,
    OP_FIN = 5'd16   // commit only
  } op_t;

endpackage

/* hw/rtl/cubic_bezier_spline_sampler.sv */
// Channel  | Signals                                   | Direction | Item
// ---------+-------------------------------------------+-----------+-----------------------------
// s_axis   | tvalid tready tdata tuser                 | in        | control point, start flag
// m_axis   | tvalid tready tdata tlast                 | out       | curve sample, last of run
// cfg      | cfg_valid cfg_ready cfg_data              | in        | smoothness register
//
// A point that does not close a segment is stored and the block stays ready. A
// closing point starts the setup steps s*s and s^3, then per sample the steps on
// the shared multiplier and two divisions of AW quotient bits in the bit-serial
// divider (AW = 29 at the default widths), plus the wait for m_axis_tready.
// s_axis_tready is low from the closing point until the last sample is taken.
// rst is synchronous: it clears the sequencer, the point count and loads
// smoothness with 10. The held points have no reset.
module cubic_bezier_spline_sampler
  import cbss_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int MAX_SMOOTH  = MAX_SMOOTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // point_x (lowest bits), point_y, zero padding to whole bytes
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // start_curve
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // sample_x (lowest bits), sample_y, zero padding to whole bytes
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  output logic                m_axis_tlast,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SMOOTH_W-1:0] cfg_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = ((2*COORD_WIDTH+7)/8)*8;
  localparam int WRAW = $clog2(MAX_SMOOTH**3 + 1);
  // Weight width: holds s^3 and the smoothness value itself.
  localparam int WW   = (WRAW > SMOOTH_W) ? WRAW : SMOOTH_W;
  localparam int PW   = WW + CW + 1;   // product and accumulator
  localparam int AW   = WW + CW - 1;   // magnitude of the numerator
  localparam int CNTW = $clog2(AW + 1);

  state_t state;
  op_t    op;
  op_t    cop;        // step whose product sits in prod
  logic   cvalid;

  logic [SMOOTH_W-1:0] smoothness;
  logic [SMOOTH_W-1:0] s_cur;
  logic [SMOOTH_W-1:0] smp_i;
  logic [SMOOTH_W-1:0] smp_r;
  logic [SMOOTH_W-1:0] s_eff;

  logic [1:0] point_phase;
  logic       have_anchor;

  // Index 0 anchor, 1 and 2 handles, 3 closing point.
  logic signed [CW-1:0] hx [0:3];
  logic signed [CW-1:0] hy [0:3];

  logic [WW-1:0] d3, rr, ii, w0, w1, w2, w3;
  logic signed [PW-1:0] prod, accx, accy;
  logic signed [PW-1:0] accx_abs, accy_abs;

  logic [WW-1:0]        mul_a;
  logic signed [CW-1:0] mul_b;
  logic signed [PW-1:0] mul_res;

  logic [AW-1:0]   dq;
  logic [WW-1:0]   rem;
  logic            dneg;
  logic            dsel;
  logic [CNTW-1:0] dcnt;
  logic [WW:0]     rem_sh;
  logic            rem_ge;
  logic [WW:0]     rem_diff;
  logic [AW-1:0]   q_signed;

  logic signed [CW-1:0] samp_x, samp_y;
  logic                 samp_last;

  logic signed [CW-1:0] in_x, in_y;
  logic                 in_acc;

  assign in_x   = s_axis_tdata[CW-1:0];
  assign in_y   = s_axis_tdata[2*CW-1:CW];
  assign in_acc = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tdata  = DW'({samp_y, samp_x});
  assign m_axis_tlast  = samp_last;

  // Clamp smoothness into the legal range.
  always_comb begin
    if (smoothness < SMOOTH_W'(MIN_SMOOTH)) begin
      s_eff = SMOOTH_W'(MIN_SMOOTH);
    end else if (smoothness > SMOOTH_W'(MAX_SMOOTH)) begin
      s_eff = SMOOTH_W'(MAX_SMOOTH);
    end else begin
      s_eff = smoothness;
    end
  end

  assign smp_r = s_cur - smp_i;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_SS: begin
        mul_a = WW'(s_cur);
        mul_b = CW'(s_cur);
      end
      OP_S3: begin
        mul_a = prod[WW-1:0];
        mul_b = CW'(s_cur);
      end
      OP_RR: begin
        mul_a = WW'(smp_r);
        mul_b = CW'(smp_r);
      end
      OP_II: begin
        mul_a = WW'(smp_i);
        mul_b = CW'(smp_i);
      end
      OP_W0: begin
        mul_a = rr;
        mul_b = CW'(smp_r);
      end
      OP_T1: begin
        mul_a = rr;
        mul_b = CW'(smp_i);
      end
      OP_T2: begin
        mul_a = ii;
        mul_b = CW'(smp_r);
      end
      OP_W3: begin
        mul_a = ii;
        mul_b = CW'(smp_i);
      end
      OP_X0: begin
        mul_a = w0;
        mul_b = hx[0];
      end
      OP_X1: begin
        mul_a = w1;
        mul_b = hx[1];
      end
      OP_X2: begin
        mul_a = w2;
        mul_b = hx[2];
      end
      OP_X3: begin
        mul_a = w3;
        mul_b = hx[3];
      end
      OP_Y0: begin
        mul_a = w0;
        mul_b = hy[0];
      end
      OP_Y1: begin
        mul_a = w1;
        mul_b = hy[1];
      end
      OP_Y2: begin
        mul_a = w2;
        mul_b = hy[2];
      end
      OP_Y3: begin
        mul_a = w3;
        mul_b = hy[3];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_res = $signed({1'b0, mul_a}) * mul_b;

  assign accx_abs = accx[PW-1] ? -accx : accx;
  assign accy_abs = accy[PW-1] ? -accy : accy;

  // One restoring step of the divider by s^3.
  assign rem_sh   = {rem, dq[AW-1]};
  assign rem_ge   = (rem_sh >= {1'b0, d3});
  assign rem_diff = rem_sh - {1'b0, d3};
  assign q_signed = dneg ? (~dq + AW'(1)) : dq;

  // Payload: held points and products.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_acc) begin
      if (s_axis_tuser || !have_anchor) begin
        hx[0] <= in_x;
        hy[0] <= in_y;
      end else if (point_phase < 2'd2) begin
        hx[point_phase + 2'd1] <= in_x;
        hy[point_phase + 2'd1] <= in_y;
      end else begin
        hx[3] <= in_x;
        hy[3] <= in_y;
      end
    end
    // The closing point becomes the next anchor once its run is out.
    if (state == ST_OUT && m_axis_tready && samp_last) begin
      hx[0] <= hx[3];
      hy[0] <= hy[3];
    end

    if (state == ST_MUL) begin
      prod <= mul_res;
    end

    // Commit the product of the step before.
    if (cvalid) begin
      case (cop)
        OP_S3: d3 <= prod[WW-1:0];
        OP_RR: rr <= prod[WW-1:0];
        OP_II: ii <= prod[WW-1:0];
        OP_W0: w0 <= prod[WW-1:0];
        OP_T1: w1 <= prod[WW-1:0] + {prod[WW-2:0], 1'b0};
        OP_T2: w2 <= prod[WW-1:0] + {prod[WW-2:0], 1'b0};
        OP_W3: w3 <= prod[WW-1:0];
        OP_X0: accx <= prod;
        OP_X1, OP_X2, OP_X3: accx <= accx + prod;
        OP_Y0: accy <= prod;
        OP_Y1, OP_Y2, OP_Y3: accy <= accy + prod;
        default: begin
        end
      endcase
    end
  end

  // Control: sequencer, divider, output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      op            <= OP_SS;
      cop           <= OP_SS;
      cvalid        <= 1'b0;
      smoothness    <= SMOOTH_RESET;
      point_phase   <= 2'd0;
      have_anchor   <= 1'b0;
      m_axis_tvalid <= 1'b0;
      dsel          <= 1'b0;
      dcnt          <= '0;
    end else begin
      if (cfg_valid) begin
        smoothness <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser || !have_anchor) begin
              point_phase <= 2'd0;
              have_anchor <= 1'b1;
            end else if (point_phase < 2'd2) begin
              point_phase <= point_phase + 2'd1;
            end else begin
              // Segment closed: latch s and start the setup steps.
              s_cur  <= s_eff;
              smp_i  <= '0;
              op     <= OP_SS;
              cvalid <= 1'b0;
              state  <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          cop    <= op;
          cvalid <= (op != OP_FIN);
          if (op == OP_FIN) begin
            // accx is complete; accy gets its last term this cycle.
            dq    <= accx_abs[AW-1:0];
            dneg  <= accx[PW-1];
            rem   <= '0;
            dsel  <= 1'b0;
            dcnt  <= '0;
            state <= ST_DIV;
          end else begin
            op <= op_t'(op + 5'd1);
          end
        end
        ST_DIV: begin
          if (dcnt == CNTW'(AW)) begin
            if (!dsel) begin
              samp_x <= q_signed[CW-1:0];
              dq     <= accy_abs[AW-1:0];
              dneg   <= accy[PW-1];
              rem    <= '0;
              dsel   <= 1'b1;
              dcnt   <= '0;
            end else begin
              samp_y        <= q_signed[CW-1:0];
              samp_last     <= (smp_i == s_cur);
              m_axis_tvalid <= 1'b1;
              state         <= ST_OUT;
            end
          end else begin
            rem  <= rem_ge ? rem_diff[WW-1:0] : rem_sh[WW-1:0];
            dq   <= {dq[AW-2:0], rem_ge};
            dcnt <= dcnt + CNTW'(1);
          end
        end
        ST_OUT: begin
          // Hold the sample until it is taken.
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (samp_last) begin
              point_phase <= 2'd0;
              state       <= ST_IDLE;
            end else begin
              smp_i  <= smp_i + SMOOTH_W'(1);
              op     <= OP_RR;
              cvalid <= 1'b0;
              state  <= ST_MUL;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
